// ===== rtl/mept_pkg.sv =====
// Package for the mesh edge pairing table.
// Holds default parameter values, port field widths and the result status codes.
// No dependencies.
package mept_pkg;

    // Default sizing of the table and of the index fields.
    localparam int DEF_EDGE_SLOTS          = 1024;
    localparam int DEF_VERTEX_INDEX_BITS   = 20;
    localparam int DEF_TRIANGLE_INDEX_BITS = 20;

    // Fixed widths of the stream fields.
    localparam int FIELD_IDX_W   = 20;
    localparam int SLOT_FIELD_W  = 10;
    localparam int COUNT_FIELD_W = 11;
    localparam int COUNT_MAX     = 2047;
    localparam int IN_TDATA_W    = 64;
    localparam int OUT_TDATA_W   = 24;

    // Outcome of one edge lookup.
    typedef enum logic [1:0] {
        ST_NEW       = 2'd0,
        ST_PAIRED    = 2'd1,
        ST_COLLISION = 2'd2,
        ST_FULL      = 2'd3
    } edge_status_t;

endpackage

// ===== rtl/mesh_edge_pairing_table.sv =====
// Mesh edge pairing table: one triangle edge per input transfer, one result per edge.
// An edge is taken in S_IDLE and compared in S_SCAN with the slots filled so far, the scan
// stopping at the first match; one slot is compared per cycle, and S_COMMIT registers the result.
// One edge at a time: the next is taken only once the result is registered, which waits for a free output.
// Reset (rst_n, asynchronous, active low) empties the table at once: the fill count is
// cleared, so no clearing pass is run and the first edge is taken straight after reset.
module mesh_edge_pairing_table
    import mept_pkg::*;
#(
    parameter int EDGE_SLOTS          = DEF_EDGE_SLOTS,
    parameter int VERTEX_INDEX_BITS   = DEF_VERTEX_INDEX_BITS,
    parameter int TRIANGLE_INDEX_BITS = DEF_TRIANGLE_INDEX_BITS
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // s_tdata: vertex_a[19:0], vertex_b[39:20], triangle[59:40], zero pad[63:60]
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // m_tdata: status[1:0], slot[11:2], open_edge_count[22:12], zero pad[23]
    output logic [OUT_TDATA_W-1:0] m_tdata
);

    localparam int SLOT_W  = $clog2(EDGE_SLOTS);
    localparam int CNT_W   = SLOT_W + 1;
    localparam int VB      = VERTEX_INDEX_BITS;
    localparam int TB      = TRIANGLE_INDEX_BITS;
    localparam int KEY_W   = 2 * VB;
    localparam int ENTRY_W = 1 + 2 * TB + KEY_W;

    typedef struct packed {
        logic             paired;
        logic [TB-1:0]    second_owner;
        logic [TB-1:0]    first_owner;
        logic [KEY_W-1:0] key;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_COMMIT
    } state_t;

    state_t             state_reg,      state_next;
    logic [KEY_W-1:0]   key_reg,        key_next;
    logic [TB-1:0]      tri_reg,        tri_next;
    logic [CNT_W-1:0]   scan_idx_reg,   scan_idx_next;
    logic               rd_valid_reg,   rd_valid_next;
    logic [SLOT_W-1:0]  rd_idx_reg,     rd_idx_next;
    logic               hit_reg,        hit_next;
    logic [SLOT_W-1:0]  hit_idx_reg,    hit_idx_next;
    logic               hit_paired_reg, hit_paired_next;
    logic [TB-1:0]      hit_first_reg,  hit_first_next;
    logic [CNT_W-1:0]   fill_reg,       fill_next;
    logic [CNT_W-1:0]   open_reg,       open_next;
    logic               m_tvalid_reg,   m_tvalid_next;
    edge_status_t       status_reg,     status_next;
    logic [SLOT_FIELD_W-1:0]  slot_reg,  slot_next;
    logic [COUNT_FIELD_W-1:0] count_reg, count_next;

    logic [VB-1:0]     vert_a;
    logic [VB-1:0]     vert_b;
    logic [VB-1:0]     vert_lo;
    logic [VB-1:0]     vert_hi;
    logic              issue;
    logic              match;
    logic              out_free;
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    entry_t            ram_wr_data;
    entry_t            rd_entry;
    logic [31:0]       slot_ext;
    logic [31:0]       open_ext;

    // Input fields cut or extended to the configured index widths.
    assign vert_a  = VB'(s_tdata[FIELD_IDX_W-1:0]);
    assign vert_b  = VB'(s_tdata[2*FIELD_IDX_W-1:FIELD_IDX_W]);
    assign vert_lo = (vert_a < vert_b) ? vert_a : vert_b;
    assign vert_hi = (vert_a < vert_b) ? vert_b : vert_a;

    // Entry memory: key, owners and the paired flag of every slot.
    mept_entry_ram #(
        .DEPTH  (EDGE_SLOTS),
        .DATA_W (ENTRY_W),
        .ADDR_W (SLOT_W)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (issue),
        .rd_addr (scan_idx_reg[SLOT_W-1:0]),
        .rd_data (rd_entry)
    );

    // Scan control: one slot read issued per cycle, the previous one compared.
    assign issue    = (state_reg == S_SCAN) && (scan_idx_reg != fill_reg);
    assign match    = rd_valid_reg && (rd_entry.key == key_reg);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE);

    // Sequencer next-state logic.
    always_comb
    begin
        state_next      = state_reg;
        key_next        = key_reg;
        tri_next        = tri_reg;
        scan_idx_next   = scan_idx_reg;
        rd_valid_next   = rd_valid_reg;
        rd_idx_next     = rd_idx_reg;
        hit_next        = hit_reg;
        hit_idx_next    = hit_idx_reg;
        hit_paired_next = hit_paired_reg;
        hit_first_next  = hit_first_reg;
        fill_next       = fill_reg;
        open_next       = open_reg;
        m_tvalid_next   = m_tvalid_reg;
        status_next     = status_reg;
        slot_next       = slot_reg;
        count_next      = count_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = hit_idx_reg;
        ram_wr_data     = '0;
        slot_ext        = 32'(hit_idx_reg);
        open_ext        = 32'(open_reg);

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    key_next      = {vert_lo, vert_hi};
                    tri_next      = TB'(s_tdata[3*FIELD_IDX_W-1:2*FIELD_IDX_W]);
                    scan_idx_next = '0;
                    rd_valid_next = 1'b0;
                    state_next    = S_SCAN;
                end
            end

            S_SCAN:
            begin
                rd_valid_next = issue;
                rd_idx_next   = scan_idx_reg[SLOT_W-1:0];
                if (issue)
                begin
                    scan_idx_next = scan_idx_reg + CNT_W'(1);
                end
                if (match)
                begin
                    hit_next        = 1'b1;
                    hit_idx_next    = rd_idx_reg;
                    hit_paired_next = rd_entry.paired;
                    hit_first_next  = rd_entry.first_owner;
                    rd_valid_next   = 1'b0;
                    state_next      = S_COMMIT;
                end
                else if (!issue && !rd_valid_reg)
                begin
                    hit_next   = 1'b0;
                    state_next = S_COMMIT;
                end
            end

            S_COMMIT:
            begin
                if (out_free)
                begin
                    m_tvalid_next = 1'b1;
                    state_next    = S_IDLE;
                    if (hit_reg)
                    begin
                        slot_ext = 32'(hit_idx_reg);
                        if (hit_paired_reg)
                        begin
                            status_next = ST_COLLISION;
                        end
                        else
                        begin
                            // Second owner arrives: record it and close the edge.
                            status_next              = ST_PAIRED;
                            ram_wr_en                = 1'b1;
                            ram_wr_addr              = hit_idx_reg;
                            ram_wr_data.paired       = 1'b1;
                            ram_wr_data.second_owner = tri_reg;
                            ram_wr_data.first_owner  = hit_first_reg;
                            ram_wr_data.key          = key_reg;
                            if (open_reg != '0)
                            begin
                                open_next = open_reg - CNT_W'(1);
                            end
                        end
                    end
                    else if (fill_reg == CNT_W'(EDGE_SLOTS))
                    begin
                        status_next = ST_FULL;
                        slot_ext    = '0;
                    end
                    else
                    begin
                        // New edge goes into the next free slot.
                        status_next             = ST_NEW;
                        slot_ext                = 32'(fill_reg);
                        ram_wr_en               = 1'b1;
                        ram_wr_addr             = fill_reg[SLOT_W-1:0];
                        ram_wr_data.paired      = 1'b0;
                        ram_wr_data.first_owner = tri_reg;
                        ram_wr_data.key         = key_reg;
                        fill_next               = fill_reg + CNT_W'(1);
                        open_next               = open_reg + CNT_W'(1);
                    end
                    open_ext   = 32'(open_next);
                    slot_next  = slot_ext[SLOT_FIELD_W-1:0];
                    count_next = (open_ext > 32'(COUNT_MAX)) ? COUNT_FIELD_W'(COUNT_MAX)
                                                             : open_ext[COUNT_FIELD_W-1:0];
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rd_valid_reg <= 1'b0;
            fill_reg     <= '0;
            open_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            rd_valid_reg <= rd_valid_next;
            fill_reg     <= fill_next;
            open_reg     <= open_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        tri_reg        <= tri_next;
        scan_idx_reg   <= scan_idx_next;
        rd_idx_reg     <= rd_idx_next;
        hit_reg        <= hit_next;
        hit_idx_reg    <= hit_idx_next;
        hit_paired_reg <= hit_paired_next;
        hit_first_reg  <= hit_first_next;
        status_reg     <= status_next;
        slot_reg       <= slot_next;
        count_reg      <= count_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, count_reg, slot_reg, status_reg};

`ifndef SYNTH
    // The fill count never passes the table size.
    assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CNT_W'(EDGE_SLOTS))
        else $error("fill count beyond table size");

    // Open edges are a subset of the filled slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        open_reg <= fill_reg)
        else $error("open edge count exceeds filled slots");

    // A taken edge makes the block busy in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input taken while an edge is still being looked up");

    // A dropped edge reports slot zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (m_tdata[1:0] == ST_FULL)) |-> (m_tdata[11:2] == '0))
        else $error("dropped edge with non-zero slot");

    // A new edge result always follows a fill count increment.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) && (status_reg == ST_NEW) |-> (fill_reg == $past(fill_reg) + CNT_W'(1)))
        else $error("new edge without a slot taken");
`endif

endmodule

// ===== rtl/mept_entry_ram.sv =====
// Single write port, single read port table memory with a registered read.
// Used by mesh_edge_pairing_table to hold one entry per edge slot.
// No package dependencies.
module mept_entry_ram #(
    parameter int DEPTH  = 1024,
    parameter int DATA_W = 81,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port, data registered.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the mesh edge pairing table: streams triangle edges in, checks results.
// Typed directed rows carry their result; every other result is compared with a predictor kept in step
// with the table on each input transfer. Depends on mept_pkg and mesh_edge_pairing_table.
module tb_top;
    import mept_pkg::*;

    localparam int          SLOTS = DEF_EDGE_SLOTS;
    localparam logic [19:0] VMAX  = 20'hFFFFF;

    typedef struct packed {
        edge_status_t             status;
        logic [SLOT_FIELD_W-1:0]  slot;
        logic [COUNT_FIELD_W-1:0] count;
    } edge_result_t;

    typedef struct packed {
        logic [19:0]  vert_a;
        logic [19:0]  vert_b;
        logic [19:0]  tri_id;
        logic         typed;
        edge_result_t res;
    } edge_row_t;

    // Directed edges. Rows marked typed carry their result; the rest use the predictor.
    localparam edge_row_t DIRECTED_EDGES [0:17] = '{
        '{20'd5,       20'd3,       20'd0,       1'b1, '{ST_NEW,       10'd0, 11'd1}},
        '{20'd3,       20'd5,       20'd1,       1'b1, '{ST_PAIRED,    10'd0, 11'd0}},
        '{20'd5,       20'd3,       20'd2,       1'b1, '{ST_COLLISION, 10'd0, 11'd0}},
        '{VMAX,        VMAX,        VMAX,        1'b1, '{ST_NEW,       10'd1, 11'd1}},
        '{20'd0,       20'd0,       20'd0,       1'b1, '{ST_NEW,       10'd2, 11'd2}},
        '{20'd0,       VMAX,        20'h55555,   1'b1, '{ST_NEW,       10'd3, 11'd3}},
        '{VMAX,        20'd0,       20'h55555,   1'b1, '{ST_PAIRED,    10'd3, 11'd2}},
        '{20'd0,       20'd0,       20'd0,       1'b1, '{ST_PAIRED,    10'd2, 11'd1}},
        '{VMAX,        VMAX,        20'd0,       1'b1, '{ST_PAIRED,    10'd1, 11'd0}},
        '{VMAX,        VMAX,        VMAX,        1'b1, '{ST_COLLISION, 10'd1, 11'd0}},
        '{20'hAAAAA,   20'h55555,   20'hAAAAA,   1'b1, '{ST_NEW,       10'd4, 11'd1}},
        '{20'h55555,   20'hAAAAA,   20'h55555,   1'b1, '{ST_PAIRED,    10'd4, 11'd0}},
        '{20'd1,       20'd2,       20'd3,       1'b0, '{ST_NEW,       10'd0, 11'd0}},
        '{20'd2,       20'd1,       20'd4,       1'b0, '{ST_NEW,       10'd0, 11'd0}},
        '{20'd2,       20'd1,       20'd5,       1'b0, '{ST_NEW,       10'd0, 11'd0}},
        '{20'd1,       20'd0,       20'd7,       1'b0, '{ST_NEW,       10'd0, 11'd0}},
        '{20'h80000,   20'h7FFFF,   20'h80000,   1'b0, '{ST_NEW,       10'd0, 11'd0}},
        '{20'h7FFFF,   20'h80000,   20'h7FFFF,   1'b0, '{ST_NEW,       10'd0, 11'd0}}
    };

    logic                   clk;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    // Predicted contents of the edge table.
    int           key_slot [logic [39:0]];
    logic [39:0]  slot_key [SLOTS];
    logic [19:0]  slot_first [SLOTS];
    bit           slot_paired [SLOTS];
    int           slots_taken = 0;
    int           open_count  = 0;

    // Slots grouped by owner count, used to build pairs and collisions.
    int           open_slots [$];
    int           paired_slots [$];

    edge_result_t pending_results [$];
    edge_result_t oldest_result;
    int           errors          = 0;
    int           sender_idle_pct = 0;
    int           stall_pct       = 0;

    mesh_edge_pairing_table u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Overall time limit for the run.
    initial
    begin
        #40_000_000;
        $display("FAILURE");
        $finish;
    end

    // Looks one edge up in the predicted table and updates it as the block should.
    function automatic edge_result_t pair_edge(logic [19:0] a, logic [19:0] b, logic [19:0] t);
        logic [19:0]  lo;
        logic [19:0]  hi;
        logic [39:0]  key;
        int           s;
        edge_result_t r;
        lo  = (a < b) ? a : b;
        hi  = (a < b) ? b : a;
        key = {lo, hi};
        s   = 0;
        if (key_slot.exists(key))
        begin
            s = key_slot[key];
            if (!slot_paired[s])
            begin
                slot_paired[s] = 1'b1;
                if (open_count > 0)
                    open_count--;
                r.status = ST_PAIRED;
            end
            else
                r.status = ST_COLLISION;
        end
        else if (slots_taken >= SLOTS)
            r.status = ST_FULL;
        else
        begin
            s              = slots_taken;
            key_slot[key]  = s;
            slot_key[s]    = key;
            slot_first[s]  = t;
            slot_paired[s] = 1'b0;
            slots_taken++;
            open_count++;
            r.status = ST_NEW;
        end
        r.slot  = SLOT_FIELD_W'(s);
        r.count = (open_count > COUNT_MAX) ? COUNT_FIELD_W'(COUNT_MAX)
                                           : COUNT_FIELD_W'(open_count);
        return r;
    endfunction

    // Offers one edge, waits for its transfer and records the expected result.
    task automatic send_edge(logic [19:0] a, logic [19:0] b, logic [19:0] t,
                             logic typed, edge_result_t typed_res);
        edge_result_t r;
        int           hits [$];
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, t, b, a};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        r = pair_edge(a, b, t);
        if (r.status == ST_NEW)
            open_slots = {open_slots, int'(r.slot)};
        else if (r.status == ST_PAIRED)
        begin
            hits = open_slots.find_first_index(x) with (x == int'(r.slot));
            if (hits.size() > 0)
                open_slots.delete(hits[0]);
            paired_slots = {paired_slots, int'(r.slot)};
        end
        pending_results = {pending_results, (typed ? typed_res : r)};
    endtask

    // Mostly fresh edges and their partners, with some collisions and odd keys mixed in.
    task automatic random_edge();
        logic [19:0] a;
        logic [19:0] b;
        logic [19:0] t;
        int          pick;
        int          s;
        a    = 20'($urandom);
        b    = 20'($urandom);
        t    = 20'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35)
            ;
        else if (pick < 70 && open_slots.size() > 0)
        begin
            s = open_slots[$urandom_range(0, open_slots.size() - 1)];
            {a, b} = slot_key[s];
            if ($urandom_range(0, 1) == 1)
                {a, b} = {b, a};
            if ($urandom_range(0, 4) == 0)
                t = slot_first[s];
        end
        else if (pick < 82 && paired_slots.size() > 0)
        begin
            s = paired_slots[$urandom_range(0, paired_slots.size() - 1)];
            {a, b} = slot_key[s];
            if ($urandom_range(0, 1) == 1)
                {a, b} = {b, a};
        end
        else if (pick < 92)
        begin
            case ($urandom_range(0, 3))
                0: b = a;
                1: a = '0;
                2: a = VMAX;
                default: t = VMAX;
            endcase
        end
        send_edge(a, b, t, 1'b0, '0);
    endtask

    task automatic set_idle(int phase);
        case (phase % 4)
            0: begin sender_idle_pct = 0;  stall_pct = 0;  end
            1: begin sender_idle_pct = 53; stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  stall_pct = 53; end
            default: begin sender_idle_pct = 22; stall_pct = 22; end
        endcase
    endtask

    // Holds the sender off until every outstanding result has arrived.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Receiver: random back-pressure and the check of each result transfer.
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= stall_pct);
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none, got %h", $time, m_tdata);
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                if (m_tdata[1:0] !== oldest_result.status)
                begin
                    errors++;
                    $display("%0t: status expected %0d, got %0d",
                             $time, oldest_result.status, m_tdata[1:0]);
                end
                if (m_tdata[11:2] !== oldest_result.slot)
                begin
                    errors++;
                    $display("%0t: slot expected %0d, got %0d",
                             $time, oldest_result.slot, m_tdata[11:2]);
                end
                if (m_tdata[22:12] !== oldest_result.count)
                begin
                    errors++;
                    $display("%0t: open edge count expected %0d, got %0d",
                             $time, oldest_result.count, m_tdata[22:12]);
                end
            end
        end
    end

    // Stimulus sequence.
    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed edges with no idling.
        set_idle(0);
        foreach (DIRECTED_EDGES[i])
            send_edge(DIRECTED_EDGES[i].vert_a, DIRECTED_EDGES[i].vert_b,
                      DIRECTED_EDGES[i].tri_id, DIRECTED_EDGES[i].typed,
                      DIRECTED_EDGES[i].res);
        drain();

        // Random edges under each idling pattern, draining between patterns.
        for (int phase = 0; phase < 4; phase++)
        begin
            set_idle(phase);
            repeat (158) random_edge();
            drain();
        end

        set_idle(0);
        drain();
        repeat (SLOTS + 16) @(posedge clk);
        if (errors == 0 && pending_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
